@@ rtl/pic_pkg.sv @@
package pic_pkg;

	localparam int CharW   = 8;
	localparam int PosW    = 4;
	localparam int ResW    = 5;
	localparam int DayW    = 6;
	localparam int MonW    = 5;
	localparam int StatusW = 4;
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 32;

	localparam logic [PosW-1:0] DashPos     = 4'd6;
	localparam logic [PosW-1:0] LastPos     = 4'd10;
	localparam logic [PosW-1:0] PosSaturate = 4'd12;

	localparam logic [CharW-1:0] AsciiZero = 8'h30;
	localparam logic [CharW-1:0] AsciiOne  = 8'h31;
	localparam logic [CharW-1:0] AsciiNine = 8'h39;
	localparam logic [CharW-1:0] AsciiDash = 8'h2d;

	// register indexes on the configuration port
	typedef enum logic {
		REG_FOREIGN_MODE = 1'b0,
		REG_EXPECTED_SEX = 1'b1
	} reg_idx_t;

	// result codes, first failure wins
	typedef enum logic [StatusW-1:0] {
		ST_OK         = 4'd0,
		ST_DIGIT      = 4'd1,
		ST_GENDER     = 4'd2,
		ST_LEAP_DAY   = 4'd3,
		ST_SERIAL     = 4'd4,
		ST_CHECK_CHAR = 4'd5,
		ST_LEN_DASH   = 4'd6,
		ST_MONTH      = 4'd7,
		ST_DAY        = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		SEX_FEMALE = 2'd0,
		SEX_MALE   = 2'd1,
		SEX_ANY    = 2'd2,
		SEX_ANY_HI = 2'd3
	} sex_sel_t;

	typedef struct packed {
		logic              foreign_mode;
		logic [1:0]        expected_sex;
	} cfg_t;

	typedef struct packed {
		status_t           status;
		logic [CharW-1:0]  check_char;
		logic              sex;
	} result_t;

	// (10 * r) mod 31 for a residue r
	function automatic logic [ResW-1:0] times10_mod31(input logic [ResW-1:0] r);
		logic [ResW-1:0] v;
		unique case (r)
			5'd0:  v = 5'd0;   5'd1:  v = 5'd10;  5'd2:  v = 5'd20;  5'd3:  v = 5'd30;
			5'd4:  v = 5'd9;   5'd5:  v = 5'd19;  5'd6:  v = 5'd29;  5'd7:  v = 5'd8;
			5'd8:  v = 5'd18;  5'd9:  v = 5'd28;  5'd10: v = 5'd7;   5'd11: v = 5'd17;
			5'd12: v = 5'd27;  5'd13: v = 5'd6;   5'd14: v = 5'd16;  5'd15: v = 5'd26;
			5'd16: v = 5'd5;   5'd17: v = 5'd15;  5'd18: v = 5'd25;  5'd19: v = 5'd4;
			5'd20: v = 5'd14;  5'd21: v = 5'd24;  5'd22: v = 5'd3;   5'd23: v = 5'd13;
			5'd24: v = 5'd23;  5'd25: v = 5'd2;   5'd26: v = 5'd12;  5'd27: v = 5'd22;
			5'd28: v = 5'd1;   5'd29: v = 5'd11;  5'd30: v = 5'd21;
			default: v = 5'd0;
		endcase
		return v;
	endfunction

	// check symbol: 0-9, A-F, H, J-N, P, R-Y
	function automatic logic [CharW-1:0] check_symbol(input logic [ResW-1:0] r);
		logic [CharW-1:0] c;
		unique case (r)
			5'd0:  c = "0"; 5'd1:  c = "1"; 5'd2:  c = "2"; 5'd3:  c = "3";
			5'd4:  c = "4"; 5'd5:  c = "5"; 5'd6:  c = "6"; 5'd7:  c = "7";
			5'd8:  c = "8"; 5'd9:  c = "9"; 5'd10: c = "A"; 5'd11: c = "B";
			5'd12: c = "C"; 5'd13: c = "D"; 5'd14: c = "E"; 5'd15: c = "F";
			5'd16: c = "H"; 5'd17: c = "J"; 5'd18: c = "K"; 5'd19: c = "L";
			5'd20: c = "M"; 5'd21: c = "N"; 5'd22: c = "P"; 5'd23: c = "R";
			5'd24: c = "S"; 5'd25: c = "T"; 5'd26: c = "U"; 5'd27: c = "V";
			5'd28: c = "W"; 5'd29: c = "X"; 5'd30: c = "Y";
			default: c = "0";
		endcase
		return c;
	endfunction

	// highest digit allowed at a position
	function automatic logic [3:0] digit_max(input logic [PosW-1:0] pos);
		logic [3:0] m;
		unique case (pos)
			4'd0:    m = 4'd3;
			4'd2:    m = 4'd1;
			default: m = 4'd9;
		endcase
		return m;
	endfunction

	function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] m);
		logic [DayW-1:0] d;
		unique case (m)
			5'd2:                   d = 6'd28;
			5'd4, 5'd6, 5'd9, 5'd11: d = 6'd30;
			default:                d = 6'd31;
		endcase
		return d;
	endfunction

endpackage

@@ rtl/pic_cfg.sv @@
module pic_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pic_pkg::CfgAddrW-1:0]    paddr,
	input  logic [pic_pkg::CfgDataW-1:0]    pwdata,
	output logic [pic_pkg::CfgDataW-1:0]    prdata,
	output logic                            pready,
	output pic_pkg::cfg_t                   cfg
);
	import pic_pkg::*;

	logic       foreign_mode_q;
	logic [1:0] expected_sex_q;
	reg_idx_t   idx;

	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;

	// write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreign_mode_q <= 1'b0;
			expected_sex_q <= SEX_ANY;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_FOREIGN_MODE: foreign_mode_q <= pwdata[0];
				REG_EXPECTED_SEX: expected_sex_q <= pwdata[1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_FOREIGN_MODE: prdata[0]   = foreign_mode_q;
			REG_EXPECTED_SEX: prdata[1:0] = expected_sex_q;
		endcase
	end

	assign cfg.foreign_mode = foreign_mode_q;
	assign cfg.expected_sex = expected_sex_q;

endmodule

@@ rtl/pic_scan.sv @@
module pic_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [pic_pkg::CharW-1:0]  char_code,
	input  logic                       last,
	input  pic_pkg::cfg_t              cfg,
	output pic_pkg::result_t           result
);
	import pic_pkg::*;

	logic [PosW-1:0] char_position_q;
	logic [ResW-1:0] check_residue_q;
	logic [DayW-1:0] day_value_q;
	logic [MonW-1:0] month_value_q;
	logic            digit_fault_q;
	logic            dash_seen_q;
	logic            serial_low_flag_q;
	logic            odd_tenth_digit_q;

	logic [ResW-1:0] res_n;
	logic [DayW-1:0] day_n;
	logic [MonW-1:0] mon_n;
	logic            fault_n, dash_n, serial_n, odd_n;
	logic            is_digit;
	logic [3:0]      d;
	logic [ResW:0]   res_sum;
	logic [CharW-1:0] expect_c;
	status_t         status;

	assign is_digit = (char_code >= AsciiZero) && (char_code <= AsciiNine);
	assign d        = is_digit ? 4'(char_code - AsciiZero) : 4'd0;
	assign res_sum  = {1'b0, times10_mod31(check_residue_q)} + {2'b00, d};

	// fold one character into the kept state
	always_comb begin
		res_n    = check_residue_q;
		day_n    = day_value_q;
		mon_n    = month_value_q;
		fault_n  = digit_fault_q;
		dash_n   = dash_seen_q;
		serial_n = serial_low_flag_q;
		odd_n    = odd_tenth_digit_q;
		if (char_position_q == DashPos) begin
			if (char_code == AsciiDash) dash_n = 1'b1;
		end else if (char_position_q < LastPos) begin
			if (!is_digit || d > digit_max(char_position_q)) fault_n = 1'b1;
			res_n = (res_sum >= 6'd31) ? 5'(res_sum - 6'd31) : res_sum[ResW-1:0];
			if (char_position_q < 4'd2) begin
				day_n = 6'({day_value_q, 3'b000} + {day_value_q, 1'b0} + {5'd0, d});
			end else if (char_position_q < 4'd4) begin
				mon_n = 5'({month_value_q, 3'b000} + {month_value_q, 1'b0} + {4'd0, d});
			end else if (char_position_q == 4'd7 || char_position_q == 4'd8) begin
				if (char_code != AsciiZero) serial_n = 1'b0;
			end else if (char_position_q == 4'd9) begin
				if (char_code != AsciiZero && char_code != AsciiOne) serial_n = 1'b0;
				odd_n = !(is_digit && !d[0]);
			end
		end
	end

	assign expect_c = check_symbol(res_n);

	// pick the first failing check
	always_comb begin
		priority if (char_position_q != LastPos || !dash_n)          status = ST_LEN_DASH;
		else if (cfg.foreign_mode)                                   status = ST_OK;
		else if (fault_n)                                            status = ST_DIGIT;
		else if (serial_n)                                           status = ST_SERIAL;
		else if (!cfg.expected_sex[1] && (odd_n != cfg.expected_sex[0]))
			status = ST_GENDER;
		else if (char_code != expect_c)                              status = ST_CHECK_CHAR;
		else if (mon_n == 5'd2 && day_n == 6'd29)                    status = ST_LEAP_DAY;
		else if (mon_n < 5'd1 || mon_n > 5'd12)                      status = ST_MONTH;
		else if (day_n < 6'd1 || day_n > month_days(mon_n))          status = ST_DAY;
		else                                                         status = ST_OK;
	end

	assign result.status     = status;
	assign result.check_char = expect_c;
	assign result.sex        = odd_n;

	// hold state; clear after the last character, saturate the position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_position_q   <= '0;
			check_residue_q   <= '0;
			day_value_q       <= '0;
			month_value_q     <= '0;
			digit_fault_q     <= 1'b0;
			dash_seen_q       <= 1'b0;
			serial_low_flag_q <= 1'b1;
			odd_tenth_digit_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				char_position_q   <= '0;
				check_residue_q   <= '0;
				day_value_q       <= '0;
				month_value_q     <= '0;
				digit_fault_q     <= 1'b0;
				dash_seen_q       <= 1'b0;
				serial_low_flag_q <= 1'b1;
				odd_tenth_digit_q <= 1'b0;
			end else begin
				if (char_position_q < PosSaturate) char_position_q <= char_position_q + 4'd1;
				check_residue_q   <= res_n;
				day_value_q       <= day_n;
				month_value_q     <= mon_n;
				digit_fault_q     <= fault_n;
				dash_seen_q       <= dash_n;
				serial_low_flag_q <= serial_n;
				odd_tenth_digit_q <= odd_n;
			end
		end
	end

endmodule

@@ rtl/personal_id_code_validator.sv @@
// Identity code checker for codes of the form DDMMYY-NNNC, fed one ASCII
// character per transfer with tlast on the final character. One result
// transfer (status, computed check character, sex from the tenth character)
// comes out for each tlast character and none for the others. A character
// is taken every cycle while s_tready is high: it is registered, folded into
// the running state, and a tlast character's result is then registered in
// the output register. The whole path stalls only while a result waits in
// the output register and m_tready is low. Write foreign_mode (0x0) and
// expected_sex (0x4) only while no code is in flight.
module personal_id_code_validator (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] char_code
	input  logic                            s_tlast,   // last
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,   // [3:0] status, [11:4] computed_check_char,
	                                                   // [12] sex_from_code, [15:13] zero
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pic_pkg::CfgAddrW-1:0]    paddr,
	input  logic [pic_pkg::CfgDataW-1:0]    pwdata,
	output logic [pic_pkg::CfgDataW-1:0]    prdata,
	output logic                            pready
);
	import pic_pkg::*;

	cfg_t             cfg;
	result_t          result;
	logic             advance;
	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             last_s1;
	logic             out_valid_q;
	result_t          out_q;

	pic_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// move everything forward unless a result is stuck
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	pic_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.char_code (char_s1),
		.last      (last_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && last_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.sex, out_q.check_char, out_q.status};

endmodule
